[rtl/core/gray_gradient_edge_threshold_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the gray gradient edge threshold core
// Two macros, one for a same-cycle implication and one for next-cycle.
// ---------------------------------------------------------------------------
`ifndef GRAY_GRADIENT_EDGE_THRESHOLD_CORE_ASSERT_SVH
`define GRAY_GRADIENT_EDGE_THRESHOLD_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define GGET_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gget assertion failed");
// next-cycle implication
`define GGET_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gget assertion failed");
`else
`define GGET_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GGET_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/gget_pkg.sv]
// ---------------------------------------------------------------------------
// gget_pkg
// Types and constants shared by the edge threshold core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gget_pkg;

  localparam int PIX_W    = 8;
  localparam int SIZE_W   = 11;
  localparam int OUT_POS_W = 10;
  localparam int SIZE_CMP_W = 14;   // holds sizes up to 16383
  localparam int SUM_W    = 10;

  // x / 3 == (x * 683) >> 11 for all x below 2048
  localparam int GRAY_RECIP = 683;
  localparam int GRAY_SHIFT = 11;
  localparam int PROD_W     = 20;

  localparam logic [PIX_W-1:0] VAL_EDGE = 8'd0;
  localparam logic [PIX_W-1:0] VAL_FLAT = 8'd255;

  // configuration register map
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RST     = 11'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RST    = 11'd1024;
  localparam logic [PIX_W-1:0]  THRESHOLD_RST = 8'd40;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [PIX_W-1:0]  threshold;
  } gget_cfg_t;

  // position flags of one pixel
  typedef struct packed {
    logic has_upper;   // a row lies above, so a result is owed for it
    logic last_col;
    logic last_row;
  } gget_flags_t;

endpackage

`default_nettype wire

[rtl/core/gget_if.sv]
// ---------------------------------------------------------------------------
// gget_if
// Valid/ready channels for incoming pixels and outgoing results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gget_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface gget_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic [9:0] out_column;
  logic [9:0] out_row;
  logic       last_of_run;
  logic       end_of_frame;

  modport source (output valid, out_value, out_column, out_row, last_of_run, end_of_frame,
                  input ready);
  modport sink   (input valid, out_value, out_column, out_row, last_of_run, end_of_frame,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/gget_line_buf.sv]
// ---------------------------------------------------------------------------
// gget_line_buf
// One-row gray line buffer: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gget_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [gget_pkg::PIX_W-1:0]    wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [gget_pkg::PIX_W-1:0]    rdata_r
);

  logic [gget_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/gget_cfg.sv]
// ---------------------------------------------------------------------------
// gget_cfg
// APB register file: width, height, threshold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gget_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [gget_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [gget_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [gget_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output gget_pkg::gget_cfg_t                     cfg
);

  gget_pkg::gget_cfg_t cfg_r;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= gget_pkg::WIDTH_RST;
      cfg_r.height    <= gget_pkg::HEIGHT_RST;
      cfg_r.threshold <= gget_pkg::THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        gget_pkg::REG_WIDTH:     cfg_r.width     <= pwdata[gget_pkg::SIZE_W-1:0];
        gget_pkg::REG_HEIGHT:    cfg_r.height    <= pwdata[gget_pkg::SIZE_W-1:0];
        gget_pkg::REG_THRESHOLD: cfg_r.threshold <= pwdata[gget_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gget_pkg::REG_WIDTH:     prdata = gget_pkg::CFG_DATA_W'(cfg_r.width);
      gget_pkg::REG_HEIGHT:    prdata = gget_pkg::CFG_DATA_W'(cfg_r.height);
      gget_pkg::REG_THRESHOLD: prdata = gget_pkg::CFG_DATA_W'(cfg_r.threshold);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/gget_emit.sv]
// ---------------------------------------------------------------------------
// gget_emit
// Result stage: holds one pixel, decides edge/flat, issues up to two beats
// through an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gray_gradient_edge_threshold_core_assert.svh"

module gget_emit #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [gget_pkg::PIX_W-1:0]    gray,
  input  wire logic [gget_pkg::PIX_W-1:0]    above,
  input  wire logic [CW-1:0]                 col,
  input  wire logic [RW-1:0]                 row,
  input  wire gget_pkg::gget_flags_t         flags,
  input  wire logic [gget_pkg::PIX_W-1:0]    right,      // line buffer read, valid while held
  input  wire logic [gget_pkg::PIX_W-1:0]    threshold,
  output logic                               free,
  gget_res_if.source                         res
);

  logic                       s1_valid_r;
  logic                       s1_phase_r;   // upper beat already issued
  logic [gget_pkg::PIX_W-1:0] s1_gray_r;
  logic [gget_pkg::PIX_W-1:0] s1_above_r;
  logic [CW-1:0]              s1_col_r;
  logic [RW-1:0]              s1_row_r;
  gget_pkg::gget_flags_t      s1_flags_r;

  logic                       out_valid_r;
  logic [gget_pkg::PIX_W-1:0] out_value_r;
  logic [gget_pkg::OUT_POS_W-1:0] out_col_r;
  logic [gget_pkg::OUT_POS_W-1:0] out_row_r;
  logic                       out_last_r;
  logic                       out_eof_r;

  logic                       pend_upper;
  logic                       need_push;
  logic                       out_room;
  logic                       push;
  logic                       done;
  logic [gget_pkg::PIX_W-1:0] d_right;
  logic [gget_pkg::PIX_W-1:0] d_below;
  logic                       is_edge;
  logic [gget_pkg::PIX_W-1:0] upper_val;
  logic [RW-1:0]              upper_row;

  assign pend_upper = s1_flags_r.has_upper && !s1_phase_r;
  assign need_push  = s1_valid_r && (pend_upper || s1_flags_r.last_row);
  assign out_room   = !out_valid_r || res.ready;
  assign push       = need_push && out_room;
  assign done       = s1_valid_r &&
                      (!need_push || (push && !(pend_upper && s1_flags_r.last_row)));
  assign free       = !s1_valid_r || done;

  always_comb begin
    d_right   = (s1_above_r >= right) ? s1_above_r - right : right - s1_above_r;
    d_below   = (s1_above_r >= s1_gray_r) ? s1_above_r - s1_gray_r : s1_gray_r - s1_above_r;
    is_edge   = (d_right >= threshold) || (d_below >= threshold);
    upper_row = s1_row_r - RW'(1);
    if (s1_flags_r.last_col) begin
      upper_val = s1_above_r;
    end else begin
      upper_val = is_edge ? gget_pkg::VAL_EDGE : gget_pkg::VAL_FLAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
      s1_phase_r <= 1'b0;
    end else if (done) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else if (push) begin
      s1_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_gray_r  <= gray;
      s1_above_r <= above;
      s1_col_r   <= col;
      s1_row_r   <= row;
      s1_flags_r <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_col_r <= gget_pkg::OUT_POS_W'(s1_col_r);
      if (pend_upper) begin
        out_value_r <= upper_val;
        out_row_r   <= gget_pkg::OUT_POS_W'(upper_row);
        out_last_r  <= !s1_flags_r.last_row;
        out_eof_r   <= 1'b0;
      end else begin
        out_value_r <= s1_gray_r;
        out_row_r   <= gget_pkg::OUT_POS_W'(s1_row_r);
        out_last_r  <= 1'b1;
        out_eof_r   <= s1_flags_r.last_col;
      end
    end
  end

  assign res.valid        = out_valid_r;
  assign res.out_value    = out_value_r;
  assign res.out_column   = out_col_r;
  assign res.out_row      = out_row_r;
  assign res.last_of_run  = out_last_r;
  assign res.end_of_frame = out_eof_r;

  `GGET_ASSERT_IMP(a_quiet_done, clk, rst_n,
    s1_valid_r && !s1_flags_r.has_upper && !s1_flags_r.last_row, done)
  `GGET_ASSERT_IMP(a_phase_only_two, clk, rst_n,
    s1_phase_r, s1_valid_r && s1_flags_r.has_upper && s1_flags_r.last_row)
  `GGET_ASSERT_IMP(a_eof_is_last, clk, rst_n,
    out_valid_r && out_eof_r, out_last_r)
  `GGET_ASSERT_NXT(a_no_load_busy, clk, rst_n,
    s1_valid_r && !done && !load, s1_valid_r)

endmodule

`default_nettype wire

[rtl/core/gray_gradient_edge_threshold_core.sv]
// Result path: the first result beat of a pixel is issued from the held-pixel register
//   through the output register; a second beat, where there is one, follows it.
// Throughput: one pixel per cycle without output stalls; last-row pixels of a frame taller
//   than one row each issue two beats through the single output register before the next.
// Reset (rst_n, synchronous, active low): position counters and handshake state clear,
//   registers return to 1024 x 1024, threshold 40; the line buffer is not cleared.
// ---------------------------------------------------------------------------
// gray_gradient_edge_threshold_core
// RGB to gray, forward-difference edge test against the row above,
// threshold to 0 / 255; last row and last column pass gray through.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gray_gradient_edge_threshold_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  gget_pix_if.sink                                in_pix,
  gget_res_if.source                              out_res,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [gget_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [gget_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [gget_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready
);

  // column and row counter widths
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CMP_W = gget_pkg::SIZE_CMP_W;

  gget_pkg::gget_cfg_t   cfg;
  gget_pkg::gget_flags_t flags;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [gget_pkg::PIX_W-1:0] col0_r;     // gray at column 0 of the current row

  logic [CW-1:0] wm1;                     // effective width - 1
  logic [RW-1:0] hm1;                     // effective height - 1
  logic          accept;
  logic          stage_free;
  logic [gget_pkg::SUM_W-1:0]  sum;
  logic [gget_pkg::PROD_W-1:0] prod;
  logic [gget_pkg::PIX_W-1:0]  gray;
  logic [gget_pkg::PIX_W-1:0]  lb_rdata;
  logic [gget_pkg::PIX_W-1:0]  above;
  logic [CW-1:0]               rd_addr;

  gget_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sizes: zero acts as one, anything past the maximum acts as the maximum.
  always_comb begin
    if (cfg.width == '0) begin
      wm1 = '0;
    end else if (CMP_W'(cfg.width) > CMP_W'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(CMP_W'(cfg.width) - CMP_W'(1));
    end
    if (cfg.height == '0) begin
      hm1 = '0;
    end else if (CMP_W'(cfg.height) > CMP_W'(MAX_HEIGHT)) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(CMP_W'(cfg.height) - CMP_W'(1));
    end
  end

  // Gray = (r + g + b) / 3 by reciprocal multiply, exact over the whole sum range.
  assign sum  = gget_pkg::SUM_W'(in_pix.red) + gget_pkg::SUM_W'(in_pix.green) +
                gget_pkg::SUM_W'(in_pix.blue);
  assign prod = gget_pkg::PROD_W'(sum) * gget_pkg::PROD_W'(gget_pkg::GRAY_RECIP);
  assign gray = prod[gget_pkg::GRAY_SHIFT +: gget_pkg::PIX_W];

  assign in_pix.ready = stage_free;
  assign accept       = in_pix.valid && stage_free;

  // Position flags; a position beyond the size counts as last.
  assign flags.has_upper = (row_r != '0);
  assign flags.last_col  = (col_r >= wm1);
  assign flags.last_row  = (row_r >= hm1);

  // Line buffer: the write of column c and the read of column c+1 share the
  // accept edge, so they never collide. The right neighbour comes from the registered
  // read port; the upper value is the previous pixel's read, or the held column 0
  // gray at the start of a row.
  assign rd_addr = col_r + CW'(1);
  assign above   = (col_r == '0) ? col0_r : lb_rdata;

  gget_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .we      (accept),
    .waddr   (col_r),
    .wdata   (gray),
    .re      (accept),
    .raddr   (rd_addr),
    .rdata_r (lb_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (flags.last_col) begin
        col_r <= '0;
        row_r <= flags.last_row ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (col_r == '0)) begin
      col0_r <= gray;
    end
  end

  gget_emit #(
    .CW (CW),
    .RW (RW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .gray      (gray),
    .above     (above),
    .col       (col_r),
    .row       (row_r),
    .flags     (flags),
    .right     (lb_rdata),
    .threshold (cfg.threshold),
    .free      (stage_free),
    .res       (out_res)
  );

endmodule

`default_nettype wire

[tb/tb_gray_gradient_edge_threshold_core.sv]
// ----------------------------------------------------------------------------
// tb_gray_gradient_edge_threshold_core
// Self-checking bench for the gray gradient edge threshold core: pixel beats
// are driven through the valid/ready channel, each accepted pixel is run
// through a local model of the gray conversion, line buffer and threshold
// test, and every result beat is compared field by field with the oldest
// outstanding prediction. A short table of directed pixels comes first, then
// random frames of mostly small sizes, one full-width row and a few frames
// shrunk in mid-flight. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gray_gradient_edge_threshold_core;

  localparam int          MAX_DIM        = 1024;
  localparam int          RESET_CYCLES   = 11;
  localparam int          DRAIN_CYCLES   = 6;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          LONG_HOLD      = 300;   // one long output stall
  localparam int          HOLD_AFTER     = 400;   // result beats seen before that stall
  localparam int unsigned RANDOM_ITEMS   = 1600;

  // one result beat as the core presents it
  typedef struct packed {
    logic [7:0] value;
    logic [9:0] column;
    logic [9:0] row;
    logic       last;
    logic       eof;
  } edge_res_t;

  // one row of the directed table: frame setup plus one pixel; where typed is
  // set the pixel closes a 1x1 frame and its single result is written down
  typedef struct packed {
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [7:0]  thr_reg;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        typed;
    logic [7:0]  typed_value;
  } pixel_row_t;

  logic clk;
  logic rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [gget_pkg::CFG_ADDR_W-1:0] paddr;
  logic [gget_pkg::CFG_DATA_W-1:0] pwdata;
  logic [gget_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  gget_pix_if pix ();
  gget_res_if res ();

  gray_gradient_edge_threshold_core #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix),
    .out_res(res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // ---------------------------------------------------------------------------
  // Local model state: register copies, gray line buffer, raster position
  // ---------------------------------------------------------------------------
  logic [10:0] cfg_width  = gget_pkg::WIDTH_RST;
  logic [10:0] cfg_height = gget_pkg::HEIGHT_RST;
  logic [7:0]  cfg_thr    = gget_pkg::THRESHOLD_RST;
  logic [7:0]  gray_above [MAX_DIM];
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;

  edge_res_t   pending_results [$];

  int unsigned n_pixels_in  = 0;
  int unsigned n_results    = 0;
  int unsigned n_errors     = 0;
  int unsigned n_setups     = 0;
  int unsigned n_shrinks    = 0;

  // directed table: 1x1 frames from zero sizes (results typed in), then a
  // 3x3 frame at threshold zero and a 4x2 black/white frame at threshold 255
  pixel_row_t pixel_table [23] = '{
    '{11'd0, 11'd0, 8'd40,  8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{11'd0, 11'd0, 8'd40,  8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
    '{11'd0, 11'd0, 8'd40,  8'd255, 8'd255, 8'd254, 1'b1, 8'd254},
    '{11'd0, 11'd0, 8'd40,  8'd255, 8'd0,   8'd0,   1'b1, 8'd85},
    '{11'd0, 11'd0, 8'd40,  8'd1,   8'd1,   8'd0,   1'b1, 8'd0},
    '{11'd0, 11'd0, 8'd40,  8'd128, 8'd0,   8'd1,   1'b1, 8'd43},
    '{11'd3, 11'd3, 8'd0,   8'd10,  8'd20,  8'd30,  1'b0, 8'd0},
    '{11'd3, 11'd3, 8'd0,   8'd200, 8'd100, 8'd0,   1'b0, 8'd0},
    '{11'd3, 11'd3, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{11'd3, 11'd3, 8'd0,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{11'd3, 11'd3, 8'd0,   8'd17,  8'd18,  8'd19,  1'b0, 8'd0},
    '{11'd3, 11'd3, 8'd0,   8'd90,  8'd90,  8'd90,  1'b0, 8'd0},
    '{11'd3, 11'd3, 8'd0,   8'd3,   8'd4,   8'd5,   1'b0, 8'd0},
    '{11'd3, 11'd3, 8'd0,   8'd250, 8'd1,   8'd128, 1'b0, 8'd0},
    '{11'd3, 11'd3, 8'd0,   8'd64,  8'd64,  8'd64,  1'b0, 8'd0},
    '{11'd4, 11'd2, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{11'd4, 11'd2, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{11'd4, 11'd2, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{11'd4, 11'd2, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{11'd4, 11'd2, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
    '{11'd4, 11'd2, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{11'd4, 11'd2, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{11'd4, 11'd2, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // register value to effective size: zero acts as one, oversize is clipped
  function automatic int unsigned eff_size(input logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned gray_diff(input int unsigned a, input int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int d;
    d = $urandom_range(0, 99);
    if (d < 55) return 0;
    if (d < 90) return $urandom_range(1, 3);
    if (d < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_threshold();
    int d;
    d = $urandom_range(0, 9);
    if (d == 0) return 8'd0;
    if (d == 1) return 8'd255;
    if (d < 6) return 8'($urandom_range(1, 30));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      n_errors++;
    end
  endfunction

  // Works out the result beats of one accepted pixel and advances the model.
  // The result for the pixel above comes first; a last-row pixel then also
  // issues its own gray value.
  function automatic void predict_pixel(input logic [7:0] r, g, b, input bit keep);
    int unsigned w, h, gray, above, right;
    bit          lc, lr, is_edge;
    edge_res_t   item;
    w    = eff_size(cfg_width);
    h    = eff_size(cfg_height);
    gray = (int'(r) + int'(g) + int'(b)) / 3;
    lc   = (pos_col >= w - 1);
    lr   = (pos_row >= h - 1);
    if (pos_row > 0) begin
      above = gray_above[pos_col];
      if (lc) begin
        item.value = 8'(above);             // last column passes gray through
      end else begin
        right   = gray_above[pos_col + 1];
        is_edge = gray_diff(above, right) >= cfg_thr || gray_diff(above, gray) >= cfg_thr;
        item.value = is_edge ? gget_pkg::VAL_EDGE : gget_pkg::VAL_FLAT;
      end
      item.column = 10'(pos_col);
      item.row    = 10'(pos_row - 1);
      item.last   = !lr;
      item.eof    = 1'b0;
      if (keep) pending_results.push_back(item);
    end
    if (lr) begin
      item.value  = 8'(gray);
      item.column = 10'(pos_col);
      item.row    = 10'(pos_row);
      item.last   = 1'b1;
      item.eof    = lc;
      if (keep) pending_results.push_back(item);
    end
    gray_above[pos_col] = 8'(gray);
    if (lc) begin
      pos_col = 0;
      pos_row = lr ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write one register, update the model copy, read it back
  task automatic cfg_set(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] rd, mask;
    apb_access(idx, 1'b1, data, rd);
    case (idx)
      gget_pkg::REG_WIDTH: begin
        cfg_width = data[10:0];
        mask      = 32'h7FF;
      end
      gget_pkg::REG_HEIGHT: begin
        cfg_height = data[10:0];
        mask       = 32'h7FF;
      end
      default: begin
        cfg_thr = data[7:0];
        mask    = 32'hFF;
      end
    endcase
    apb_access(idx, 1'b0, '0, rd);
    check_field("register readback", data & mask, rd & mask);
  endtask

  // hold until every predicted beat has come out, then let the pipe settle
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers only change with the core idle. Upper pwdata bits are junk on
  // purpose: the core must only keep the register's own bits.
  task automatic setup_frame(input logic [10:0] wr, hr, input logic [7:0] tr);
    pix.valid <= 1'b0;
    wait_idle();
    cfg_set(gget_pkg::REG_WIDTH,     {21'($urandom_range(0, 2097151)), wr});
    cfg_set(gget_pkg::REG_HEIGHT,    {21'($urandom_range(0, 2097151)), hr});
    cfg_set(gget_pkg::REG_THRESHOLD, {24'($urandom_range(0, 16777215)), tr});
    n_setups++;
  endtask

  // ---------------------------------------------------------------------------
  // Pixel side
  // ---------------------------------------------------------------------------
  // Offers one pixel beat and waits for it to be taken. valid stays high into
  // the next beat unless a gap is drawn. The model runs at the accepting edge,
  // ahead of the earliest result the beat can cause.
  task automatic send_pixel(input logic [7:0] r, g, b, input bit typed,
                            input logic [7:0] tval, input bit steady);
    int        gap;
    edge_res_t item;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
    n_pixels_in++;
    if (typed) begin
      // 1x1 frame: gray value, position 0/0, last of run and end of frame
      item.value  = tval;
      item.column = '0;
      item.row    = '0;
      item.last   = 1'b1;
      item.eof    = 1'b1;
      pending_results.push_back(item);
    end
    predict_pixel(r, g, b, !typed);
  endtask

  // One frame of random content. With shrink set the frame is cut short by a
  // width/height no larger than before (and a new threshold) part-way through, so the
  // position may lie beyond the new size; pixels then keep coming until the
  // raster position wraps to the top left again.
  task automatic run_frame(input logic [10:0] wr, hr, input logic [7:0] tr, input bit shrink);
    int unsigned total, cut, sent, base, style;
    bit          steady;
    logic [7:0]  r, g, b;
    setup_frame(wr, hr, tr);
    total  = eff_size(wr) * eff_size(hr);
    cut    = (shrink && total > 1) ? $urandom_range(1, total - 1) : 0;
    style  = $urandom_range(0, 9);
    base   = $urandom_range(0, 240);
    steady = ($urandom_range(0, 3) == 0);
    sent   = 0;
    do begin
      if (cut != 0 && sent == cut) begin
        n_shrinks++;
        setup_frame(11'($urandom_range(1, eff_size(cfg_width))),
                    11'($urandom_range(1, eff_size(cfg_height))), pick_threshold());
      end
      if (style < 4) begin
        // anything goes
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
      end else if (style < 9) begin
        // smooth area, differences land around typical thresholds
        r = 8'(base + $urandom_range(0, 15));
        g = 8'(base + $urandom_range(0, 15));
        b = 8'(base + $urandom_range(0, 15));
      end else begin
        // saturated channels
        r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      send_pixel(r, g, b, 1'b0, 8'd0, steady);
      sent++;
    end while (pos_col != 0 || pos_row != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, quiet stretches, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_ready
    int  hold;
    bit  held_long;
    held_long = 1'b0;
    res.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_long && n_results >= HOLD_AFTER && pix.valid) begin
        // sender keeps offering beats: the core must fill up and stall
        held_long = 1'b1;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        res.ready <= 1'b1;
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          res.ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // every accepted result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    edge_res_t want;
    if (rst_n && res.valid && res.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: value %0d col %0d row %0d",
                 $time, res.out_value, res.out_column, res.out_row);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_value",    want.value,  res.out_value);
        check_field("out_column",   want.column, res.out_column);
        check_field("out_row",      want.row,    res.out_row);
        check_field("last_of_run",  want.last,   res.last_of_run);
        check_field("end_of_frame", want.eof,    res.end_of_frame);
      end
    end
  end

  // run ends when neither channel has moved a beat for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix.valid && pix.ready) || (res.valid && res.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat on either channel for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] rd;
    int unsigned frame_no;
    rst_n     <= 1'b0;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers straight out of reset
    apb_access(gget_pkg::REG_WIDTH, 1'b0, '0, rd);
    check_field("image_width after reset", gget_pkg::WIDTH_RST, rd[10:0]);
    apb_access(gget_pkg::REG_HEIGHT, 1'b0, '0, rd);
    check_field("image_height after reset", gget_pkg::HEIGHT_RST, rd[10:0]);
    apb_access(gget_pkg::REG_THRESHOLD, 1'b0, '0, rd);
    check_field("edge_threshold after reset", gget_pkg::THRESHOLD_RST, rd[7:0]);

    // directed table; a new frame setup whenever a row asks for one
    foreach (pixel_table[i]) begin
      if (pixel_table[i].width_reg != cfg_width || pixel_table[i].height_reg != cfg_height ||
          pixel_table[i].thr_reg != cfg_thr)
        setup_frame(pixel_table[i].width_reg, pixel_table[i].height_reg,
                    pixel_table[i].thr_reg);
      send_pixel(pixel_table[i].red, pixel_table[i].green, pixel_table[i].blue,
                 pixel_table[i].typed, pixel_table[i].typed_value, 1'b0);
    end

    // random frames, mostly small; one full-width row thrown in, set from an
    // oversize width register value
    frame_no = 0;
    while (n_pixels_in < RANDOM_ITEMS) begin
      frame_no++;
      if (frame_no == 5) begin
        run_frame(11'($urandom_range(1025, 2047)), 11'd1, pick_threshold(), 1'b0);
      end else begin
        run_frame(($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 16)),
                  ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 6)),
                  pick_threshold(), $urandom_range(0, 7) == 0);
      end
    end

    pix.valid <= 1'b0;
    wait_idle();

    $display("Run: %0d pixel beats in, %0d result beats out, %0d frame setups.",
             n_pixels_in, n_results, n_setups);
    $display("Covered zero and oversize sizes, thresholds 0 and 255, %0d mid-frame shrinks.",
             n_shrinks);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
